FILE: hw/rtl/hash_group_count_linear_probe_defines.svh
// assertion macros shared by the hash group counter modules
`ifndef HASH_GROUP_COUNT_LINEAR_PROBE_DEFINES_SVH
`define HASH_GROUP_COUNT_LINEAR_PROBE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define HGC_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// consequent checked in the cycle after the antecedent
`define HGC_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

FILE: hw/rtl/hgc_pkg.sv
// shared constants, state type and control structs of the hash group counter
`timescale 1ns / 1ps

package hgc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;

    localparam int KEY_IN_W  = 32;
    localparam int HOME_W    = 10;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_PROBE
    } hgc_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic mod_step;
        logic mod_read;
        logic advance;
        logic resolve;
    } hgc_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic home_fast;
        logic mod_last;
        logic hit;
        logic empty;
        logic probe_last;
    } hgc_sts_t;

endpackage

FILE: hw/rtl/hgc_ifs.sv
// channel interfaces: item input, result output and size register write
`timescale 1ns / 1ps

interface hgc_item_if;
    logic                           valid;
    logic                           ready;
    logic [hgc_pkg::KEY_IN_W-1:0]   key;
    logic [hgc_pkg::HOME_W-1:0]     home_slot;

    modport source (output valid, output key, output home_slot, input ready);
    modport sink (input valid, input key, input home_slot, output ready);
endinterface

interface hgc_result_if;
    logic                           valid;
    logic                           ready;
    logic [hgc_pkg::SLOT_W-1:0]     slot;
    logic [hgc_pkg::COUNT_W-1:0]    new_count;
    logic                           inserted;
    logic                           table_full;

    modport source (output valid, output slot, output new_count, output inserted,
                    output table_full, input ready);
    modport sink (input valid, input slot, input new_count, input inserted,
                  input table_full, output ready);
endinterface

interface hgc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hgc_pkg::CFG_W-1:0]      table_size;

    modport source (output valid, output table_size, input ready);
    modport sink (input valid, input table_size, output ready);
endinterface

FILE: hw/rtl/hgc_ctrl.sv
// controller state machine: clear sweep, modulo steps, probe walk, result handoff
`timescale 1ns / 1ps
`include "hash_group_count_linear_probe_defines.svh"

module hgc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  hgc_pkg::hgc_sts_t sts,
    output hgc_pkg::hgc_cmd_t cmd
);

    hgc_pkg::hgc_state_t state_reg;
    hgc_pkg::hgc_state_t state_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic                out_free;
    logic                found;

    assign out_free = !out_vld_reg || result_ready;
    assign found    = sts.hit || sts.empty || sts.probe_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hgc_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = hgc_pkg::ST_IDLE;
                end
            end
            hgc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sts.home_fast ? hgc_pkg::ST_PROBE : hgc_pkg::ST_MOD;
                end
            end
            hgc_pkg::ST_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = hgc_pkg::ST_READ;
                end
            end
            hgc_pkg::ST_READ:
            begin
                state_next = hgc_pkg::ST_PROBE;
            end
            hgc_pkg::ST_PROBE:
            begin
                if (found && out_free)
                begin
                    state_next = hgc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hgc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            hgc_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            hgc_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            hgc_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            hgc_pkg::ST_READ:
            begin
                cmd.mod_read = 1'b1;
            end
            hgc_pkg::ST_PROBE:
            begin
                cmd.resolve = found && out_free;
                cmd.advance = !found;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.resolve)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hgc_pkg::ST_CLEAR;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign result_valid = out_vld_reg;

    `HGC_ASSERT_SAME(a_held_result_kept, clk, rst_n, out_vld_reg && !result_ready, !cmd.resolve, "held result overwritten")
    `HGC_ASSERT_NEXT(a_valid_from_resolve, clk, rst_n, !out_vld_reg && !cmd.resolve, !out_vld_reg, "result valid without resolve")
    `HGC_ASSERT_SAME(a_no_skip_found, clk, rst_n, cmd.advance, !(sts.hit || sts.empty), "probe walked past a usable slot")

endmodule

FILE: hw/rtl/hgc_dpath.sv
// datapath: key and count memories, modulo unit, probe position and result register
`timescale 1ns / 1ps
`include "hash_group_count_linear_probe_defines.svh"

module hgc_dpath #(
    parameter int TABLE_DEPTH = hgc_pkg::TABLE_DEPTH,
    parameter int KEY_WIDTH   = hgc_pkg::KEY_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hgc_pkg::hgc_cmd_t             cmd,
    output hgc_pkg::hgc_sts_t             sts,
    input  logic [hgc_pkg::KEY_IN_W-1:0]  item_key,
    input  logic [hgc_pkg::HOME_W-1:0]    item_home_slot,
    input  logic                          cfg_we,
    input  logic [hgc_pkg::CFG_W-1:0]     cfg_table_size,
    output logic [hgc_pkg::SLOT_W-1:0]    result_slot,
    output logic [hgc_pkg::COUNT_W-1:0]   result_new_count,
    output logic                          result_inserted,
    output logic                          result_table_full
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int SZ_W     = IDX_W + 1;
    localparam int HOME_W   = hgc_pkg::HOME_W;
    localparam int SLOT_W   = hgc_pkg::SLOT_W;
    localparam int COUNT_W  = hgc_pkg::COUNT_W;
    localparam int CFG_W    = hgc_pkg::CFG_W;
    localparam int CW       = (CFG_W > SZ_W) ? CFG_W : SZ_W;
    localparam int HS_W     = (HOME_W > SZ_W) ? HOME_W : SZ_W;
    localparam int MC_W     = $clog2(HOME_W);
    localparam int SIZE_RST = (hgc_pkg::CFG_RESET > TABLE_DEPTH) ? TABLE_DEPTH
                                                                  : hgc_pkg::CFG_RESET;

    logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0]   cnt_mem [TABLE_DEPTH];

    logic [SZ_W-1:0]      size_reg;
    logic [SZ_W-1:0]      size_next;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic [IDX_W-1:0]     clr_addr_next;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [HOME_W-1:0]    home_reg;
    logic [MC_W-1:0]      mcnt_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [SZ_W-1:0]      nprobe_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [COUNT_W-1:0]   rd_cnt_reg;

    logic [SZ_W-1:0]      rem_sh;
    logic [IDX_W-1:0]     rem_next;
    logic [SZ_W-1:0]      pos_plus;
    logic [IDX_W-1:0]     pos_next;
    logic [CW-1:0]        cfg_wide;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_key;
    logic [COUNT_W-1:0]   wr_cnt;

    logic [SLOT_W-1:0]    out_slot_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;
    logic                 out_ins_reg;
    logic                 out_full_reg;

    // size register, clamped to 1..TABLE_DEPTH on write
    always_comb
    begin
        cfg_wide = CW'(cfg_table_size);
        if (cfg_wide == '0)
        begin
            size_next = SZ_W'(1);
        end
        else if (cfg_wide > CW'(TABLE_DEPTH))
        begin
            size_next = SZ_W'(TABLE_DEPTH);
        end
        else
        begin
            size_next = SZ_W'(cfg_wide);
        end
    end

    assign clr_addr_next = sts.clear_last ? '0 : clr_addr_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SZ_W'(SIZE_RST);
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= size_next;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_next;
            end
        end
    end

    // restoring remainder, one home bit per step
    always_comb
    begin
        rem_sh = {rem_reg, home_reg[HOME_W-1]};
        if (rem_sh >= size_reg)
        begin
            rem_next = IDX_W'(rem_sh - size_reg);
        end
        else
        begin
            rem_next = IDX_W'(rem_sh);
        end
    end

    assign pos_plus = {1'b0, pos_reg} + SZ_W'(1);
    assign pos_next = (pos_plus >= size_reg) ? '0 : IDX_W'(pos_plus);

    always_comb
    begin
        sts.clear_last = (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1));
        sts.home_fast  = (HS_W'(item_home_slot) < HS_W'(size_reg));
        sts.mod_last   = (mcnt_reg == '0);
        sts.hit        = (rd_key_reg == key_reg);
        sts.empty      = (rd_key_reg == '0);
        sts.probe_last = ((nprobe_reg + SZ_W'(1)) == size_reg);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pos_next;
        if (cmd.load)
        begin
            rd_en   = sts.home_fast;
            rd_addr = IDX_W'(item_home_slot);
        end
        else if (cmd.mod_read)
        begin
            rd_en   = 1'b1;
            rd_addr = rem_reg;
        end
        else if (cmd.advance)
        begin
            rd_en   = 1'b1;
            rd_addr = pos_next;
        end
    end

    always_comb
    begin
        wr_en   = cmd.clear_step || (cmd.resolve && (sts.hit || sts.empty));
        wr_addr = cmd.clear_step ? clr_addr_reg : pos_reg;
        wr_key  = cmd.clear_step ? '0 : key_reg;
        if (cmd.clear_step)
        begin
            wr_cnt = '0;
        end
        else if (sts.hit)
        begin
            wr_cnt = rd_cnt_reg + COUNT_W'(1);
        end
        else
        begin
            wr_cnt = COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= KEY_WIDTH'(item_key);
            home_reg   <= item_home_slot;
            mcnt_reg   <= MC_W'(HOME_W - 1);
            rem_reg    <= '0;
            pos_reg    <= IDX_W'(item_home_slot);
            nprobe_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            home_reg <= home_reg << 1;
            mcnt_reg <= mcnt_reg - MC_W'(1);
            rem_reg  <= rem_next;
        end
        if (cmd.mod_read)
        begin
            pos_reg    <= rem_reg;
            nprobe_reg <= '0;
        end
        if (cmd.advance)
        begin
            pos_reg    <= pos_next;
            nprobe_reg <= nprobe_reg + SZ_W'(1);
        end
        if (cmd.resolve)
        begin
            if (sts.hit || sts.empty)
            begin
                out_slot_reg <= SLOT_W'(pos_reg);
                out_cnt_reg  <= wr_cnt;
                out_ins_reg  <= !sts.hit;
                out_full_reg <= 1'b0;
            end
            else
            begin
                out_slot_reg <= '0;
                out_cnt_reg  <= '0;
                out_ins_reg  <= 1'b0;
                out_full_reg <= 1'b1;
            end
        end
    end

    assign result_slot       = out_slot_reg;
    assign result_new_count  = out_cnt_reg;
    assign result_inserted   = out_ins_reg;
    assign result_table_full = out_full_reg;

    `HGC_ASSERT_NEXT(a_clear_wraps, clk, rst_n, cmd.clear_step && sts.clear_last, clr_addr_reg == '0, "clear address did not wrap")
    `HGC_ASSERT_NEXT(a_full_result, clk, rst_n, cmd.resolve && !(sts.hit || sts.empty), out_full_reg && (out_cnt_reg == '0) && !out_ins_reg, "bad table full result")

endmodule

FILE: hw/rtl/hash_group_count_linear_probe.sv
// top level of the linear probing hash group counter
//
//  channel  dir  beat contents                              accepted when
//  item     in   key, home_slot                             item.valid && item.ready
//  result   out  slot, new_count, inserted, table_full      result.valid && result.ready
//  cfg      in   table_size                                 cfg.valid (ready tied high)
//
// after reset the block sweeps both memories to zero with item.ready low;
// size register writes are taken throughout
// an item is accepted and then probed slot by slot from its home slot, and
// ends at once when the home slot matches or is empty; the single read port
// of the key/count memories sets one probe per cycle
// a home_slot at or above the size in use adds the bit-serial remainder
// (10 steps) and the first read
// the result sits in an output register; the next item is accepted while it
// waits, and a probe that finds its slot stalls until that register is free
`timescale 1ns / 1ps

module hash_group_count_linear_probe #(
    parameter int TABLE_DEPTH = hgc_pkg::TABLE_DEPTH,
    parameter int KEY_WIDTH   = hgc_pkg::KEY_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    hgc_item_if.sink      item,
    hgc_result_if.source  result,
    hgc_cfg_if.sink       cfg
);

    // command and status between controller and datapath
    hgc_pkg::hgc_cmd_t cmd;
    hgc_pkg::hgc_sts_t sts;

    // the size register can always take a write
    assign cfg.ready = 1'b1;

    hgc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // memories, remainder unit, probe pointer and result register
    hgc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .item_key          (item.key),
        .item_home_slot    (item.home_slot),
        .cfg_we            (cfg.valid),
        .cfg_table_size    (cfg.table_size),
        .result_slot       (result.slot),
        .result_new_count  (result.new_count),
        .result_inserted   (result.inserted),
        .result_table_full (result.table_full)
    );

endmodule

FILE: tb/sv/hash_group_count_linear_probe_tb.sv
// testbench of the linear probing hash group counter: directed and random beats
`timescale 1ns / 1ps

module hash_group_count_linear_probe_tb;

    // widths and depth of the block
    localparam int TABLE_DEPTH  = hgc_pkg::TABLE_DEPTH;
    localparam int KEY_IN_W     = hgc_pkg::KEY_IN_W;
    localparam int HOME_W       = hgc_pkg::HOME_W;
    localparam int SLOT_W       = hgc_pkg::SLOT_W;
    localparam int COUNT_W      = hgc_pkg::COUNT_W;
    localparam int CFG_W        = hgc_pkg::CFG_W;
    localparam int CFG_RESET    = hgc_pkg::CFG_RESET;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    // idle and stall rates, percent of cycles
    localparam int PCT_NONE     = 0;
    localparam int PCT_LIGHT    = 21;
    localparam int PCT_HEAVY    = 84;
    // longest single sender gap
    localparam int GAP_MAX      = 40;
    // settle time after the last result, a few probe lengths
    localparam int DRAIN_CYCLES = 40;
    // hard stop, far beyond the slowest run of this stimulus
    localparam int LIMIT_NS     = 100_000_000;
    // keys per random phase that come back again and again
    localparam int POOL_MAX     = 64;

    // table_size values at and beyond the edges of the register
    localparam logic [CFG_W-1:0] SIZE_ZERO = 11'd0;
    localparam logic [CFG_W-1:0] SIZE_ONE  = 11'd1;
    localparam logic [CFG_W-1:0] SIZE_FULL = 11'd1024;
    localparam logic [CFG_W-1:0] SIZE_MAX  = 11'h7FF;

    // one expected result beat
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] new_count;
        logic               inserted;
        logic               table_full;
    } count_beat_t;

    logic clk;
    logic rst_n;

    hgc_item_if   item_ch ();
    hgc_result_if result_ch ();
    hgc_cfg_if    cfg_ch ();

    hash_group_count_linear_probe i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // own copy of the table and of the size register
    logic [KEY_IN_W-1:0] slot_keys   [TABLE_DEPTH];
    logic [COUNT_W-1:0]  slot_counts [TABLE_DEPTH];
    logic [CFG_W-1:0]    size_reg;

    // expected result beats, oldest first
    count_beat_t pending_counts[$];
    int unsigned err_count;

    int sender_idle_pct;
    int recv_stall_pct;

    logic [KEY_IN_W-1:0] key_pool [POOL_MAX];

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // size register as the block uses it: 0 acts as 1, anything past the
    // table depth is clipped to the depth
    function automatic int unsigned slots_in_use();
        if (size_reg == '0)
            return 1;
        if (size_reg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(size_reg);
    endfunction

    // linear probe from the home slot; equality is checked before emptiness,
    // so key 0 counts up in the first empty slot it meets without taking it
    function automatic count_beat_t update_group_count(input logic [KEY_IN_W-1:0] key,
                                                       input logic [HOME_W-1:0] home);
        int unsigned span;
        int unsigned pos;
        count_beat_t beat;
        span = slots_in_use();
        pos = int'(home) % span;
        // table full unless a probe below finds a match or a hole
        beat = '0;
        beat.table_full = 1'b1;
        for (int n = 0; n < span; n++)
        begin
            if (slot_keys[pos] == key)
            begin
                slot_counts[pos] = slot_counts[pos] + 1'b1;
                beat.slot = pos[SLOT_W-1:0];
                beat.new_count = slot_counts[pos];
                beat.inserted = 1'b0;
                beat.table_full = 1'b0;
                return beat;
            end
            if (slot_keys[pos] == '0)
            begin
                slot_keys[pos] = key;
                slot_counts[pos] = 1;
                beat.slot = pos[SLOT_W-1:0];
                beat.new_count = 1;
                beat.inserted = 1'b1;
                beat.table_full = 1'b0;
                return beat;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        return beat;
    endfunction

    // stand-in hash so that a key keeps one home slot within a phase
    function automatic logic [HOME_W-1:0] hash_home(input logic [KEY_IN_W-1:0] key);
        logic [HOME_W-1:0] folded;
        folded = key[9:0] ^ key[19:10] ^ key[29:20] ^ {8'd0, key[31:30]};
        return HOME_W'(int'(folded) % slots_in_use());
    endfunction

    // ------------------------------------------------------------------
    // clock, limit and result side
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // runaway guard
    initial
    begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result ready: a fresh coin each cycle at the current stall rate
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        count_beat_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("result beat with no expectation waiting: slot %0d count %0d",
                       result_ch.slot, result_ch.new_count);
                err_count++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (result_ch.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, result_ch.slot);
                    err_count++;
                end
                if (result_ch.new_count !== want.new_count)
                begin
                    $error("new_count: expected %0d, got %0d", want.new_count,
                           result_ch.new_count);
                    err_count++;
                end
                if (result_ch.inserted !== want.inserted)
                begin
                    $error("inserted: expected %0b, got %0b", want.inserted,
                           result_ch.inserted);
                    err_count++;
                end
                if (result_ch.table_full !== want.table_full)
                begin
                    $error("table_full: expected %0b, got %0b", want.table_full,
                           result_ch.table_full);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // item and register side
    // ------------------------------------------------------------------

    // one item beat, after a random gap; the expectation is taken at the
    // edge where the beat goes across
    task automatic send_item(input logic [KEY_IN_W-1:0] key, input logic [HOME_W-1:0] home);
        int unsigned gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.key <= key;
        item_ch.home_slot <= home;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        pending_counts.push_back(update_group_count(key, home));
    endtask

    // hold items back until every expected beat has come out; it always waits
    // for a clock edge first so valid is never dropped and raised in one step
    task automatic wait_all_counted();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_table_size(input logic [CFG_W-1:0] value);
        wait_all_counted();
        cfg_ch.valid <= 1'b1;
        cfg_ch.table_size <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        size_reg = value;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // full-width key at the top slot, a repeat, then wrap past the top
    task automatic test_first_keys();
        send_item(32'hFFFF_FFFF, 10'h3FF);
        send_item(32'hFFFF_FFFF, 10'h3FF);
        send_item(32'h0000_0001, 10'h3FF);
        send_item(32'h8000_0000, 10'h000);
    endtask

    // key 0 matches an empty slot and counts there without inserting
    task automatic test_key_zero();
        send_item(32'h0000_0000, 10'd5);
        send_item(32'h0000_0000, 10'd5);
        send_item(32'h0000_0000, 10'd0);
        wait_all_counted();
    endtask

    // two slots, both taken: new keys and key 0 find no room, known keys
    // are still found, one of them across the wrap
    task automatic test_table_full();
        write_table_size(11'd2);
        send_item(32'h1234_5678, 10'd0);
        send_item(32'h0000_0000, 10'd1);
        send_item(32'h8000_0000, 10'd0);
        send_item(32'h0000_0001, 10'd1);
    endtask

    // size 0 acts as one slot, sizes above the depth act as the depth
    task automatic test_size_limits();
        write_table_size(SIZE_ZERO);
        send_item(32'h0000_0001, 10'h3FF);
        send_item(32'h5555_AAAA, 10'h2AA);
        write_table_size(SIZE_ONE);
        send_item(32'h0000_0001, 10'h155);
        write_table_size(SIZE_MAX);
        send_item(32'hFFFF_FFFF, 10'h3FF);
        send_item(32'hAAAA_5555, 10'h2AA);
        write_table_size(11'd1025);
        send_item(32'h0000_0001, 10'h3FE);
    endtask

    // home slots past the size in use start at home modulo size
    task automatic test_home_wrap();
        write_table_size(11'd16);
        send_item(32'hC3C3_3C3C, 10'h3FF);
        send_item(32'hC3C3_3C3C, 10'h20F);
        send_item(32'h0F0F_F0F0, 10'd15);
    endtask

    // one random phase at a given size and idle mix; mostly keys that recur
    // with their own home slot, plus keys already stored, key 0 and noise
    task automatic test_random_counts(input logic [CFG_W-1:0] size_value,
                                      input int sender_pct, input int recv_pct,
                                      input int n_items);
        logic [KEY_IN_W-1:0] key;
        logic [HOME_W-1:0]   home;
        int unsigned         pick;
        int unsigned         span;
        int unsigned         s;
        write_table_size(size_value);
        sender_idle_pct = sender_pct;
        recv_stall_pct = recv_pct;
        span = slots_in_use();
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        for (int n = 0; n < n_items; n++)
        begin
            // now and then let the block run completely dry
            if ($urandom_range(39) == 0)
                wait_all_counted();
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                key = key_pool[$urandom_range(POOL_MAX - 1)];
                home = hash_home(key);
            end
            else if (pick < 70)
            begin
                // a stored key, homed a few slots before where it sits
                s = $urandom_range(span - 1);
                key = slot_keys[s];
                home = HOME_W'((s + span - $urandom_range(3) % span) % span);
            end
            else if (pick < 80)
            begin
                key = $urandom();
                home = HOME_W'($urandom());
            end
            else if (pick < 85)
            begin
                key = '0;
                home = HOME_W'($urandom_range(span - 1));
            end
            else
            begin
                key = $urandom();
                home = hash_home(key);
            end
            send_item(key, home);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.key <= '0;
        item_ch.home_slot <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.table_size <= '0;
        err_count = 0;
        sender_idle_pct = PCT_LIGHT;
        recv_stall_pct = PCT_LIGHT;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_keys[i] = '0;
            slot_counts[i] = '0;
        end
        size_reg = CFG_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the clearing sweep after reset simply holds off the first beat
        test_first_keys();
        test_key_zero();
        test_table_full();
        test_size_limits();
        test_home_wrap();

        test_random_counts(11'd16, PCT_NONE, PCT_NONE, 200);
        test_random_counts(SIZE_FULL, PCT_HEAVY, PCT_NONE, 400);
        test_random_counts(11'd3, PCT_NONE, PCT_HEAVY, 150);
        test_random_counts(CFG_W'($urandom_range(300, 900)), PCT_LIGHT, PCT_LIGHT, 350);
        test_random_counts(SIZE_MAX, PCT_NONE, PCT_NONE, 400);
        test_random_counts(CFG_W'($urandom_range(1025, 2046)), PCT_NONE, PCT_HEAVY, 200);
        test_random_counts(SIZE_ONE, PCT_LIGHT, PCT_LIGHT, 100);

        wait_all_counted();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
